[rtl/core/qvr_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths, constants and helpers of the quaternion vector rotator.
package qvr_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int ANGLE_BITS = 16;

  // Internal Q1.14 components carry one guard bit for rounding overflow.
  localparam int QW = 17;
  localparam int TURN_W = 31;
  localparam int ARG_W = 31;
  localparam int ACC_W = 32;
  localparam int TRIG_W = 33;

  localparam int PRD_W = 2 * QW;
  localparam int DOT_W = PRD_W + 2;
  localparam int CR_W = PRD_W + 1;
  localparam int TD_W = DOT_W + QW;
  localparam int DIF_W = TD_W + 2;
  localparam int D22_W = DIF_W - 20;

  localparam int HORNER_STEPS = 5;
  localparam int QSIN_LAT = HORNER_STEPS + 2;
  localparam int VEC_LAT = QSIN_LAT + 1;

  localparam int Q14_DN = (COMP_WIDTH > 16) ? COMP_WIDTH - 16 : 0;
  localparam int Q14_UP = (COMP_WIDTH < 16) ? 16 - COMP_WIDTH : 0;
  localparam int Q14_RND = (COMP_WIDTH > 16) ? (1 << (COMP_WIDTH - 17)) : 0;

  localparam logic [ARG_W-1:0] Q30_ONE = ARG_W'(1) << 30;

  // Odd Taylor coefficients of sin(pi/2*u) in Q30, lowest order first.
  localparam logic [ACC_W-1:0] SIN_COEF [6] = '{
    32'd1686629713, 32'd693598668, 32'd85569306,
    32'd5026995, 32'd172272, 32'd3864
  };

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] vec_x;
    logic signed [COMP_WIDTH-1:0] vec_y;
    logic signed [COMP_WIDTH-1:0] vec_z;
    logic signed [COMP_WIDTH-1:0] axis_x;
    logic signed [COMP_WIDTH-1:0] axis_y;
    logic signed [COMP_WIDTH-1:0] axis_z;
    logic [ANGLE_BITS-1:0] turn_angle;
  } qvr_in_t;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] rot_x;
    logic signed [COMP_WIDTH-1:0] rot_y;
    logic signed [COMP_WIDTH-1:0] rot_z;
  } qvr_out_t;

  typedef struct packed {
    logic [2:0][QW-1:0] v;
    logic [2:0][QW-1:0] a;
  } qvr_vq_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] c2;
    logic signed [TRIG_W-1:0] s2;
    logic signed [TRIG_W-1:0] cs2;
  } qvr_trig_t;

  typedef struct packed {
    logic [2:0][QW-1:0] v;
    logic [2:0][D22_W-1:0] d22;
    logic [2:0][CR_W-1:0] cr;
  } qvr_vprep_t;

  // Brings a component to Q1.14, rounding half up when the field is wider.
  function automatic logic [QW-1:0] to_q14(input logic signed [COMP_WIDTH-1:0] raw);
    logic signed [COMP_WIDTH:0] t;
    logic signed [QW-1:0] r;
    t = (COMP_WIDTH + 1)'(raw) + (COMP_WIDTH + 1)'(Q14_RND);
    if (COMP_WIDTH >= 16) begin
      r = QW'(t >>> Q14_DN);
    end else begin
      r = QW'(raw) <<< Q14_UP;
    end
    return r;
  endfunction

endpackage

[rtl/core/qvr_qsin.sv]
`timescale 1ns / 1ps
// Pipelined quarter-wave sine: square, five Horner steps and a final product.
module qvr_qsin
  import qvr_pkg::*;
(
  input  logic             clk,
  input  logic [ARG_W-1:0] arg,
  output logic [ACC_W-1:0] sin_q30
);

  logic [ARG_W-1:0] x_r [QSIN_LAT-1];
  logic [ARG_W-1:0] x2_r [HORNER_STEPS];
  logic [ACC_W-1:0] acc_r [HORNER_STEPS];
  logic [ACC_W-1:0] sin_r;
  logic [2*ARG_W-1:0] sq;
  logic [ARG_W+ACC_W-1:0] fin_prd;

  assign sq = arg * arg;
  assign fin_prd = x_r[QSIN_LAT-2] * acc_r[HORNER_STEPS-1];

  always_ff @(posedge clk) begin
    x_r[0] <= arg;
    x2_r[0] <= sq[ARG_W+29:30];
    sin_r <= fin_prd[ACC_W+29:30];
  end

  for (genvar j = 0; j < QSIN_LAT - 2; j++) begin : g_xd
    always_ff @(posedge clk) begin
      x_r[j+1] <= x_r[j];
    end
  end

  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
    logic [ACC_W-1:0] acc_in;
    logic [ARG_W+ACC_W-1:0] prd;
    if (j == 0) begin : g_first
      assign acc_in = SIN_COEF[HORNER_STEPS];
    end else begin : g_next
      assign acc_in = acc_r[j-1];
    end
    assign prd = x2_r[j] * acc_in;
    always_ff @(posedge clk) begin
      acc_r[j] <= SIN_COEF[HORNER_STEPS-1-j] - prd[ACC_W+29:30];
    end
    if (j < HORNER_STEPS - 1) begin : g_x2d
      always_ff @(posedge clk) begin
        x2_r[j+1] <= x2_r[j];
      end
    end
  end

  assign sin_q30 = sin_r;

endmodule

[rtl/core/qvr_sincos.sv]
`timescale 1ns / 1ps
// Half-angle sine and cosine and the products cos^2, sin^2 and 2*cos*sin.
module qvr_sincos
  import qvr_pkg::*;
(
  input  logic              clk,
  input  logic [TURN_W-1:0] turn,
  output qvr_trig_t         trig
);

  localparam int PW = 2 * TRIG_W;
  localparam logic signed [PW-1:0] RND30 = PW'(1) <<< 29;
  localparam logic signed [PW-1:0] RND29 = PW'(1) <<< 28;

  logic [ARG_W-1:0] u, uc, arg_s, arg_c;
  logic [ACC_W-1:0] sin_s, sin_c;
  logic [QSIN_LAT-1:0] quad_r;
  logic signed [TRIG_W-1:0] s, cmag, c;
  logic signed [PW-1:0] cc, ss, cs;
  qvr_trig_t trig_r;

  // The upper half of the half-angle range swaps the roles and negates cos.
  assign u = ARG_W'(turn[29:0]);
  assign uc = Q30_ONE - u;
  assign arg_s = turn[30] ? uc : u;
  assign arg_c = turn[30] ? u : uc;

  qvr_qsin u_sin (.clk(clk), .arg(arg_s), .sin_q30(sin_s));
  qvr_qsin u_cos (.clk(clk), .arg(arg_c), .sin_q30(sin_c));

  always_ff @(posedge clk) begin
    quad_r <= {quad_r[QSIN_LAT-2:0], turn[30]};
  end

  always_comb begin
    s = $signed({1'b0, sin_s});
    cmag = $signed({1'b0, sin_c});
    c = quad_r[QSIN_LAT-1] ? -cmag : cmag;
    cc = c * c;
    ss = s * s;
    cs = c * s;
  end

  always_ff @(posedge clk) begin
    trig_r.c2 <= TRIG_W'((cc + RND30) >>> 30);
    trig_r.s2 <= TRIG_W'((ss + RND30) >>> 30);
    trig_r.cs2 <= TRIG_W'((cs + RND29) >>> 29);
  end

  assign trig = trig_r;

endmodule

[rtl/core/qvr_vecprep.sv]
`timescale 1ns / 1ps
// Axis and vector terms: dot, squared length, cross product and the D term.
module qvr_vecprep
  import qvr_pkg::*;
(
  input  logic       clk,
  input  qvr_vq_t    vq,
  output qvr_vprep_t vp
);

  localparam logic signed [DIF_W-1:0] RND20 = DIF_W'(1) <<< 19;

  logic [2:0][QW-1:0] v_d [VEC_LAT];
  logic [2:0][QW-1:0] a_d [2];
  logic [2:0][CR_W-1:0] cr_d [VEC_LAT-1];
  logic [2:0][D22_W-1:0] d_d [VEC_LAT-3];
  logic signed [PRD_W-1:0] pav_r [3];
  logic signed [PRD_W-1:0] paa_r [3];
  logic signed [PRD_W-1:0] pc1_r [3];
  logic signed [PRD_W-1:0] pc2_r [3];
  logic signed [DOT_W-1:0] dot_r, len2_r;
  logic signed [TD_W-1:0] tdot_r [3];
  logic signed [TD_W-1:0] tlen_r [3];

  always_ff @(posedge clk) begin
    v_d[0] <= vq.v;
    a_d[0] <= vq.a;
    a_d[1] <= a_d[0];
    dot_r <= DOT_W'(pav_r[0]) + DOT_W'(pav_r[1]) + DOT_W'(pav_r[2]);
    len2_r <= DOT_W'(paa_r[0]) + DOT_W'(paa_r[1]) + DOT_W'(paa_r[2]);
  end

  for (genvar k = 0; k < VEC_LAT - 1; k++) begin : g_vd
    always_ff @(posedge clk) begin
      v_d[k+1] <= v_d[k];
    end
  end

  for (genvar k = 0; k < VEC_LAT - 2; k++) begin : g_crd
    always_ff @(posedge clk) begin
      cr_d[k+1] <= cr_d[k];
    end
  end

  for (genvar k = 0; k < VEC_LAT - 4; k++) begin : g_dd
    always_ff @(posedge clk) begin
      d_d[k+1] <= d_d[k];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J1 = (i + 1) % 3;
    localparam int J2 = (i + 2) % 3;
    logic signed [DIF_W-1:0] dif;
    assign dif = (DIF_W'(tdot_r[i]) <<< 1) - DIF_W'(tlen_r[i]) + RND20;
    always_ff @(posedge clk) begin
      pav_r[i] <= $signed(vq.a[i]) * $signed(vq.v[i]);
      paa_r[i] <= $signed(vq.a[i]) * $signed(vq.a[i]);
      pc1_r[i] <= $signed(vq.a[J1]) * $signed(vq.v[J2]);
      pc2_r[i] <= $signed(vq.a[J2]) * $signed(vq.v[J1]);
      cr_d[0][i] <= CR_W'(pc1_r[i]) - CR_W'(pc2_r[i]);
      tdot_r[i] <= dot_r * $signed(a_d[1][i]);
      tlen_r[i] <= len2_r * $signed(v_d[1][i]);
      d_d[0][i] <= D22_W'(dif >>> 20);
    end
  end

  assign vp.v = v_d[VEC_LAT-1];
  assign vp.cr = cr_d[VEC_LAT-2];
  assign vp.d22 = d_d[VEC_LAT-4];

endmodule

[rtl/core/qvr_combine.sv]
`timescale 1ns / 1ps
// Weights the three terms, sums them, rounds to the output format and saturates.
module qvr_combine
  import qvr_pkg::*;
(
  input  logic       clk,
  input  qvr_trig_t  trig,
  input  qvr_vprep_t vp,
  output qvr_out_t   res
);

  localparam int P1_W = TRIG_W + QW;
  localparam int P2_W = TRIG_W + D22_W;
  localparam int P3_W = TRIG_W + CR_W;
  localparam int SUM_W = 64;
  localparam int RS = 46 - COMP_WIDTH;
  localparam logic signed [P2_W-1:0] RND8 = P2_W'(1) <<< 7;
  localparam logic signed [P3_W-1:0] RND14 = P3_W'(1) <<< 13;
  localparam logic signed [SUM_W-1:0] RNDO = SUM_W'(1) <<< (RS - 1);
  localparam logic signed [SUM_W-1:0] OMAX = (SUM_W'(1) <<< (COMP_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] OMIN = -OMAX - SUM_W'(1);

  logic signed [P1_W-1:0] p1_r [3];
  logic signed [SUM_W-1:0] r2_r [3];
  logic signed [SUM_W-1:0] r3_r [3];
  logic [2:0][COMP_WIDTH-1:0] o_r;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic signed [P2_W-1:0] p2;
    logic signed [P3_W-1:0] p3;
    logic signed [SUM_W-1:0] sum, rr, sat;
    always_comb begin
      p2 = $signed(trig.s2) * $signed(vp.d22[i]);
      p3 = $signed(trig.cs2) * $signed(vp.cr[i]);
      sum = SUM_W'(p1_r[i]) + r2_r[i] + r3_r[i];
      rr = (sum + RNDO) >>> RS;
      if (rr > OMAX) begin
        sat = OMAX;
      end else if (rr < OMIN) begin
        sat = OMIN;
      end else begin
        sat = rr;
      end
    end
    always_ff @(posedge clk) begin
      p1_r[i] <= $signed(trig.c2) * $signed(vp.v[i]);
      r2_r[i] <= SUM_W'((p2 + RND8) >>> 8);
      r3_r[i] <= SUM_W'((p3 + RND14) >>> 14);
      o_r[i] <= COMP_WIDTH'(sat);
    end
  end

  assign res.rot_x = $signed(o_r[0]);
  assign res.rot_y = $signed(o_r[1]);
  assign res.rot_z = $signed(o_r[2]);

endmodule

[rtl/core/quaternion_vector_rotate_top.sv]
`timescale 1ns / 1ps
// Top level of the quaternion vector rotator.
//
// The block rotates a vector by the quaternion built from an axis and a turn
// angle and returns the vector part of q*v*conj(q), saturated to the output
// format; the axis is not normalised, so a non-unit axis also scales the
// result by the squared norm of that quaternion. A word is taken at every
// clock edge at which start is high: busy is never asserted, so one word per
// cycle is sustained indefinitely. Each result appears on the out_ ports for
// exactly one cycle, marked by out_valid; results leave in the order their
// words arrived. The pipeline depth is set by the input register and the
// half-angle sine, a chain of seven multiply stages (square, five Horner
// steps, final product), followed by one stage for the squared trigonometric
// terms, one for the weighted products and one for the sum, rounding and
// saturation. The receiver cannot stall the block, so it must be ready to
// take every strobe. There is no configuration and no state between words.
module quaternion_vector_rotate_top
  import qvr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  qvr_in_t  in_data,
  output logic     out_valid,
  output qvr_out_t out_data
);

  localparam int NSTG = VEC_LAT + 3;

  logic accept;
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  qvr_vq_t vq_r;
  qvr_vq_t vq_nxt;
  logic [TURN_W-1:0] turn_r;
  logic [TURN_W-1:0] turn_nxt;
  qvr_trig_t trig;
  qvr_vprep_t vp;

  // The pipeline never holds off a word.
  assign busy = 1'b0;
  assign accept = start & ~busy;

  // Input stage: components to Q1.14, angle to a half-angle turn fraction.
  always_comb begin
    vq_nxt.v[0] = to_q14(in_data.vec_x);
    vq_nxt.v[1] = to_q14(in_data.vec_y);
    vq_nxt.v[2] = to_q14(in_data.vec_z);
    vq_nxt.a[0] = to_q14(in_data.axis_x);
    vq_nxt.a[1] = to_q14(in_data.axis_y);
    vq_nxt.a[2] = to_q14(in_data.axis_z);
    turn_nxt = TURN_W'(in_data.turn_angle) << (TURN_W - ANGLE_BITS);
    vld_nxt = {vld_r[NSTG-2:0], accept};
  end

  always_ff @(posedge clk) begin
    vq_r <= vq_nxt;
    turn_r <= turn_nxt;
  end

  // Valid bits travel alongside the data through every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  qvr_sincos u_sincos (.clk(clk), .turn(turn_r), .trig(trig));
  qvr_vecprep u_vecprep (.clk(clk), .vq(vq_r), .vp(vp));
  qvr_combine u_combine (.clk(clk), .trig(trig), .vp(vp), .res(out_data));

  assign out_valid = vld_r[NSTG-1];

endmodule
